// ===== rtl/arp_pkg.sv =====
// Package for the adaptive replacement engine: sizes, list and class codes,
// datapath opcodes and the command/status structs between controller and datapath.
// No dependencies.
package arp_pkg;

  localparam int MaxCapacity = 64;
  localparam int DirSize     = 2 * MaxCapacity;
  localparam int KeyBits     = 32;
  localparam int StampW      = 32;
  localparam int CapW        = 7;
  localparam int IdxW        = $clog2(DirSize);
  localparam int CntW        = $clog2(DirSize + 1);
  localparam int SumW        = CntW + 2;
  localparam int OutBits     = 2 * KeyBits + 2 + CapW;
  localparam int OutDataW    = ((OutBits + 7) / 8) * 8;
  localparam int ClsW        = 3;

  localparam logic [2:0] L_NONE = 3'd0;
  localparam logic [2:0] L_T1   = 3'd1;
  localparam logic [2:0] L_T2   = 3'd2;
  localparam logic [2:0] L_B1   = 3'd3;
  localparam logic [2:0] L_B2   = 3'd4;

  localparam logic [ClsW-1:0] CLS_NEW = 3'd0;
  localparam logic [ClsW-1:0] CLS_T1  = 3'd1;
  localparam logic [ClsW-1:0] CLS_T2  = 3'd2;
  localparam logic [ClsW-1:0] CLS_B1  = 3'd3;
  localparam logic [ClsW-1:0] CLS_B2  = 3'd4;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SCAN, OP_HIT, OP_TGT, OP_TGT_DROP, OP_DROP,
    OP_SEL_T1, OP_SEL_T2, OP_VIC, OP_DIV_START, OP_DIV_STEP, OP_P_UPD,
    OP_MOVE, OP_RNM_INIT, OP_RNM_WR, OP_RNM_END, OP_OUT, OP_CLR
  } op_e;

  typedef enum logic [2:0] {SM_FIND, SM_LRU, SM_NONE, SM_GHOST, SM_RNM} smode_e;

  typedef enum logic [2:0] {LS_FROM, LS_GHOST, LS_B1, LS_B2, LS_T1, LS_T2} lsel_e;

  typedef struct packed {
    op_e    op;
    smode_e smode;
    lsel_e  lsel;
    logic   use_vic;
    logic   cfg_we;
  } cmd_t;

  typedef struct packed {
    logic            scan_done;
    logic            scan_found;
    logic [ClsW-1:0] hit_cls;
    logic            div_done;
    logic            repl_t1;
    logic            repl_t2;
    logic            ghost_full;
    logic            ghost_nz;
    logic            t1b1_eq_c;
    logic            t1_lt_c;
    logic            b1_nz;
    logic            b2_nz;
    logic            total_ge_c;
    logic            total_ge_2c;
    logic            res_ge_c;
    logic            stamp_full;
    logic            out_full;
    logic            clr_last;
  } sts_t;

  function automatic logic [1:0] lidx(input logic [2:0] code);
    return 2'(code - 3'd1);
  endfunction

endpackage

// ===== rtl/arp_dpath.sv =====
// Datapath of the adaptive replacement engine: directory memories, list codes,
// counts, scan engine, divider, target p and the result register. Uses arp_pkg.
module arp_dpath import arp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [KeyBits-1:0]  key_i,
  input  logic [CapW-1:0]     cfg_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [OutDataW-1:0] out_data_o,
  output logic [ClsW-1:0]     out_user_o
);

  logic [KeyBits-1:0] key_mem   [DirSize];
  logic [StampW-1:0]  stamp_mem [DirSize];
  logic [2:0]         list_mem  [DirSize];
  logic [IdxW-1:0]    clr_q;
  logic [CntW-1:0]    cnt_q [4];
  logic [CntW-1:0]    cnt_d [4];

  logic [CapW-1:0]    cap_q, p_q;
  logic [StampW-1:0]  stamp_q;
  logic [CntW-1:0]    rank_q;
  logic               rfirst_q;
  logic [StampW-1:0]  rlo_q;
  logic [KeyBits-1:0] k_q, ev_key_q;
  logic [ClsW-1:0]    cls_q;
  logic               ev_valid_q, ev_recent_q;
  logic [IdxW-1:0]    tgt_q, vic_q;
  logic [2:0]         from_q, tl_q;
  logic [CntW-1:0]    rem_q, dvs_q, quo_q;

  logic               busy_q, pv_q, done_q, found_q;
  logic [IdxW-1:0]    addr_q, pidx_q, bidx_q;
  smode_e             mode_q;
  logic [2:0]         sl_q, plist_q, blist_q;
  logic [StampW-1:0]  rd_stamp_q, bstamp_q;
  logic [KeyBits-1:0] rd_key_q, bkey_q;

  logic               ov_q;
  logic [OutDataW-1:0] od_q;
  logic [ClsW-1:0]    ou_q;

  logic [2:0]         ghost_l, ml, sl_d, dec_code, lw_data;
  logic [IdxW-1:0]    mi, sw_addr, lw_addr;
  logic               match, use_st, take, dec_en, inc_en, key_we, stamp_we, list_we;
  logic [StampW-1:0]  sw_data;
  logic [CntW-1:0]    t1, t2, b1, b2, dlt;
  logic [SumW-1:0]    capx, t1b1, ghosts, res, total, psum;
  logic [CapW-1:0]    cfg_c;

  assign t1 = cnt_q[0];
  assign t2 = cnt_q[1];
  assign b1 = cnt_q[2];
  assign b2 = cnt_q[3];
  assign capx   = SumW'(cap_q);
  assign t1b1   = SumW'(t1) + SumW'(b1);
  assign ghosts = SumW'(b1) + SumW'(b2);
  assign res    = SumW'(t1) + SumW'(t2);
  assign total  = t1b1 + SumW'(t2) + SumW'(b2);
  assign ghost_l = (from_q == L_T1) ? L_B1 : L_B2;
  assign mi = cmd_i.use_vic ? vic_q : tgt_q;
  assign dlt  = (quo_q == '0) ? CntW'(1) : quo_q;
  assign psum = SumW'(p_q) + SumW'(dlt);

  always_comb begin
    case (cmd_i.lsel)
      LS_GHOST: ml = ghost_l;
      LS_T1:    ml = L_T1;
      default:  ml = L_T2;
    endcase
    case (cmd_i.lsel)
      LS_FROM:  sl_d = from_q;
      LS_GHOST: sl_d = ghost_l;
      LS_B1:    sl_d = L_B1;
      LS_B2:    sl_d = L_B2;
      LS_T1:    sl_d = L_T1;
      default:  sl_d = L_T2;
    endcase
  end

  // match per scan mode; renumber pass: oldest entry above last renumbered stamp
  always_comb begin
    case (mode_q)
      SM_FIND:  match = (plist_q != L_NONE) && (rd_key_q == k_q);
      SM_LRU:   match = (plist_q == sl_q);
      SM_NONE:  match = (plist_q == L_NONE);
      SM_GHOST: match = (plist_q == L_B1) || (plist_q == L_B2);
      SM_RNM:   match = (plist_q != L_NONE) && (rfirst_q || (rd_stamp_q > rlo_q));
      default:  match = 1'b0;
    endcase
    use_st = (mode_q == SM_LRU) || (mode_q == SM_GHOST) || (mode_q == SM_RNM);
    take = pv_q && match && (!found_q || (use_st && (rd_stamp_q < bstamp_q)));
  end

  always_comb begin
    dec_en = 1'b0;
    dec_code = L_NONE;
    inc_en = 1'b0;
    case (cmd_i.op)
      OP_MOVE: begin
        dec_code = cmd_i.use_vic ? from_q : tl_q;
        dec_en = (dec_code != L_NONE);
        inc_en = 1'b1;
      end
      OP_DROP, OP_TGT_DROP: begin
        dec_code = blist_q;
        dec_en = (blist_q != L_NONE);
      end
      default: ;
    endcase
    for (int i = 0; i < 4; i++) begin
      cnt_d[i] = cnt_q[i];
      if (dec_en && (lidx(dec_code) == 2'(i))) cnt_d[i] = cnt_d[i] - CntW'(1);
      if (inc_en && (lidx(ml) == 2'(i))) cnt_d[i] = cnt_d[i] + CntW'(1);
    end
  end

  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_c = CapW'(1);
    end else if (32'(cfg_data_i) > MaxCapacity) begin
      cfg_c = CapW'(MaxCapacity);
    end else begin
      cfg_c = cfg_data_i;
    end
  end

  always_comb begin
    list_we = 1'b0;
    lw_addr = mi;
    lw_data = ml;
    case (cmd_i.op)
      OP_MOVE: list_we = 1'b1;
      OP_DROP, OP_TGT_DROP: begin
        list_we = 1'b1;
        lw_addr = bidx_q;
        lw_data = L_NONE;
      end
      OP_CLR: begin
        list_we = 1'b1;
        lw_addr = clr_q;
        lw_data = L_NONE;
      end
      default: ;
    endcase
  end

  assign key_we   = (cmd_i.op == OP_MOVE) && (ml == L_T1);
  assign stamp_we = (cmd_i.op == OP_MOVE) || (cmd_i.op == OP_RNM_WR);
  assign sw_addr  = (cmd_i.op == OP_MOVE) ? mi : bidx_q;
  assign sw_data  = (cmd_i.op == OP_MOVE) ? stamp_q : StampW'(rank_q);

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[mi] <= k_q;
    rd_key_q <= key_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (stamp_we) stamp_mem[sw_addr] <= sw_data;
    rd_stamp_q <= stamp_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (list_we) list_mem[lw_addr] <= lw_data;
    plist_q <= list_mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) cnt_q[i] <= '0;
      clr_q <= '0;
      cap_q <= CapW'(MaxCapacity);
      p_q <= CapW'(MaxCapacity / 2);
      stamp_q <= '0;
    end else begin
      if (cmd_i.cfg_we) begin
        for (int i = 0; i < 4; i++) cnt_q[i] <= '0;
        cap_q <= cfg_c;
        p_q <= cfg_c >> 1;
      end else begin
        for (int i = 0; i < 4; i++) cnt_q[i] <= cnt_d[i];
        case (cmd_i.op)
          OP_MOVE: stamp_q <= stamp_q + StampW'(1);
          OP_P_UPD: begin
            if (cls_q == CLS_B1) begin
              p_q <= (psum > capx) ? cap_q : CapW'(psum);
            end else begin
              p_q <= (dlt > CntW'(p_q)) ? '0 : CapW'(CntW'(p_q) - dlt);
            end
          end
          OP_RNM_END: stamp_q <= StampW'(rank_q);
          OP_CLR:     clr_q <= clr_q + IdxW'(1);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        k_q <= key_i;
        ev_valid_q <= 1'b0;
        ev_key_q <= '0;
        ev_recent_q <= 1'b0;
      end
      OP_HIT: begin
        tgt_q <= bidx_q;
        tl_q <= found_q ? blist_q : L_NONE;
        cls_q <= found_q ? blist_q : CLS_NEW;
      end
      OP_TGT, OP_TGT_DROP: begin
        tgt_q <= bidx_q;
        tl_q <= L_NONE;
      end
      OP_DROP: begin
        if (bidx_q == tgt_q) tl_q <= L_NONE;
      end
      OP_SEL_T1: from_q <= L_T1;
      OP_SEL_T2: from_q <= L_T2;
      OP_VIC: begin
        vic_q <= bidx_q;
        ev_valid_q <= 1'b1;
        ev_key_q <= bkey_q;
        ev_recent_q <= (from_q == L_T1);
      end
      OP_DIV_START: begin
        rem_q <= (cls_q == CLS_B1) ? b2 : b1;
        dvs_q <= (cls_q == CLS_B1) ? b1 : b2;
        quo_q <= '0;
      end
      OP_DIV_STEP: begin
        if (rem_q >= dvs_q) begin
          rem_q <= rem_q - dvs_q;
          quo_q <= quo_q + CntW'(1);
        end
      end
      OP_RNM_INIT: begin
        rank_q <= '0;
        rfirst_q <= 1'b1;
      end
      OP_RNM_WR: begin
        rank_q <= rank_q + CntW'(1);
        rfirst_q <= 1'b0;
        rlo_q <= bstamp_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pv_q <= 1'b0;
      done_q <= 1'b0;
      found_q <= 1'b0;
      addr_q <= '0;
    end else begin
      pv_q <= busy_q;
      done_q <= pv_q && (pidx_q == IdxW'(DirSize - 1));
      if (cmd_i.op == OP_SCAN) begin
        busy_q <= 1'b1;
        addr_q <= '0;
        found_q <= 1'b0;
      end else begin
        if (busy_q) begin
          addr_q <= addr_q + IdxW'(1);
          if (addr_q == IdxW'(DirSize - 1)) busy_q <= 1'b0;
        end
        if (take) found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= addr_q;
    if (cmd_i.op == OP_SCAN) begin
      mode_q <= cmd_i.smode;
      sl_q <= sl_d;
      bidx_q <= '0;
    end else if (take) begin
      bidx_q <= pidx_q;
      bstamp_q <= rd_stamp_q;
      bkey_q <= rd_key_q;
      blist_q <= plist_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.op == OP_OUT) begin
      ov_q <= 1'b1;
    end else if (ov_q && out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_OUT) begin
      od_q <= {(OutDataW - OutBits)'(0), p_q, ev_recent_q, ev_key_q, ev_valid_q, k_q};
      ou_q <= cls_q;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign out_user_o  = ou_q;

  assign sts_o.scan_done   = done_q;
  assign sts_o.scan_found  = found_q;
  assign sts_o.hit_cls     = found_q ? blist_q : CLS_NEW;
  assign sts_o.div_done    = (rem_q < dvs_q);
  assign sts_o.repl_t1     = (t1 != '0) && ((t1 > CntW'(p_q)) ||
                             ((t1 == CntW'(p_q)) && (t2 == '0)));
  assign sts_o.repl_t2     = (t2 != '0);
  assign sts_o.ghost_full  = (ghosts >= capx);
  assign sts_o.ghost_nz    = (cnt_q[lidx(ghost_l)] != '0);
  assign sts_o.t1b1_eq_c   = (t1b1 == capx);
  assign sts_o.t1_lt_c     = (SumW'(t1) < capx);
  assign sts_o.b1_nz       = (b1 != '0);
  assign sts_o.b2_nz       = (b2 != '0);
  assign sts_o.total_ge_c  = (total >= capx);
  assign sts_o.total_ge_2c = (total >= (capx << 1));
  assign sts_o.res_ge_c    = (res >= capx);
  assign sts_o.stamp_full  = (stamp_q == '1);
  assign sts_o.out_full    = ov_q;
  assign sts_o.clr_last    = (clr_q == IdxW'(DirSize - 1));

endmodule

// ===== rtl/arp_ctrl.sv =====
// Sequencer of the adaptive replacement engine: walks lookup, adaptation,
// replace and insertion steps and issues datapath commands. Uses arp_pkg.
module arp_ctrl import arp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_FIND    = 5'd1;
  localparam logic [4:0] S_FIND_W  = 5'd2;
  localparam logic [4:0] S_DISP    = 5'd3;
  localparam logic [4:0] S_DIV     = 5'd4;
  localparam logic [4:0] S_REPL    = 5'd5;
  localparam logic [4:0] S_DEM     = 5'd6;
  localparam logic [4:0] S_DEM_W   = 5'd7;
  localparam logic [4:0] S_DEM_G   = 5'd8;
  localparam logic [4:0] S_DEM_GW  = 5'd9;
  localparam logic [4:0] S_MOVE    = 5'd10;
  localparam logic [4:0] S_RN_INIT = 5'd11;
  localparam logic [4:0] S_RN_SCAN = 5'd12;
  localparam logic [4:0] S_RN_W    = 5'd13;
  localparam logic [4:0] S_M1      = 5'd14;
  localparam logic [4:0] S_M1D     = 5'd15;
  localparam logic [4:0] S_M3      = 5'd16;
  localparam logic [4:0] S_M4      = 5'd17;
  localparam logic [4:0] S_M4W     = 5'd18;
  localparam logic [4:0] S_M4G     = 5'd19;
  localparam logic [4:0] S_OUT     = 5'd20;
  localparam logic [4:0] S_CLR     = 5'd21;

  logic [4:0] state_q, state_d, ret_q, ret_d;
  lsel_e      mvl_q, mvl_d;
  logic       dem_q, dem_d;

  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;

  always_comb begin
    state_d = state_q;
    ret_d = ret_q;
    mvl_d = mvl_q;
    dem_d = dem_q;
    cmd_o.op = OP_NONE;
    cmd_o.smode = SM_FIND;
    cmd_o.lsel = LS_T2;
    cmd_o.use_vic = 1'b0;
    cmd_o.cfg_we = cfg_valid_i && (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.op = OP_LOAD;
          state_d = S_FIND;
        end else if (cfg_valid_i) begin
          state_d = S_CLR;
        end
      end
      S_CLR: begin
        cmd_o.op = OP_CLR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_FIND: begin
        cmd_o.op = OP_SCAN;
        cmd_o.smode = SM_FIND;
        state_d = S_FIND_W;
      end
      S_FIND_W: begin
        if (sts_i.scan_done) begin
          cmd_o.op = OP_HIT;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        dem_d = 1'b0;
        mvl_d = LS_T2;
        case (sts_i.hit_cls)
          CLS_T1, CLS_T2: state_d = S_MOVE;
          CLS_B1, CLS_B2: begin
            cmd_o.op = OP_DIV_START;
            ret_d = S_MOVE;
            state_d = S_DIV;
          end
          default: state_d = S_M1;
        endcase
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.op = OP_P_UPD;
          state_d = S_REPL;
        end else begin
          cmd_o.op = OP_DIV_STEP;
        end
      end
      S_REPL: begin
        if (sts_i.repl_t1) begin
          cmd_o.op = OP_SEL_T1;
          state_d = S_DEM;
        end else if (sts_i.repl_t2) begin
          cmd_o.op = OP_SEL_T2;
          state_d = S_DEM;
        end else begin
          state_d = ret_q;
        end
      end
      S_DEM: begin
        cmd_o.op = OP_SCAN;
        cmd_o.smode = SM_LRU;
        cmd_o.lsel = LS_FROM;
        state_d = S_DEM_W;
      end
      S_DEM_W: begin
        if (sts_i.scan_done) begin
          if (sts_i.scan_found) begin
            cmd_o.op = OP_VIC;
            state_d = S_DEM_G;
          end else begin
            state_d = ret_q;
          end
        end
      end
      S_DEM_G: begin
        if (sts_i.ghost_full && sts_i.ghost_nz) begin
          cmd_o.op = OP_SCAN;
          cmd_o.smode = SM_LRU;
          cmd_o.lsel = LS_GHOST;
          state_d = S_DEM_GW;
        end else begin
          dem_d = 1'b1;
          state_d = S_MOVE;
        end
      end
      S_DEM_GW: begin
        if (sts_i.scan_done) begin
          cmd_o.op = OP_DROP;
          dem_d = 1'b1;
          state_d = S_MOVE;
        end
      end
      S_MOVE: begin
        if (sts_i.stamp_full) begin
          state_d = S_RN_INIT;
        end else begin
          cmd_o.op = OP_MOVE;
          cmd_o.lsel = dem_q ? LS_GHOST : mvl_q;
          cmd_o.use_vic = dem_q;
          dem_d = 1'b0;
          state_d = dem_q ? ret_q : S_OUT;
        end
      end
      S_RN_INIT: begin
        cmd_o.op = OP_RNM_INIT;
        state_d = S_RN_SCAN;
      end
      S_RN_SCAN: begin
        cmd_o.op = OP_SCAN;
        cmd_o.smode = SM_RNM;
        state_d = S_RN_W;
      end
      S_RN_W: begin
        if (sts_i.scan_done) begin
          if (sts_i.scan_found) begin
            cmd_o.op = OP_RNM_WR;
            state_d = S_RN_SCAN;
          end else begin
            cmd_o.op = OP_RNM_END;
            state_d = S_MOVE;
          end
        end
      end
      S_M1: begin
        ret_d = S_M3;
        if (sts_i.t1b1_eq_c) begin
          if (sts_i.t1_lt_c) begin
            if (sts_i.b1_nz) begin
              cmd_o.op = OP_SCAN;
              cmd_o.smode = SM_LRU;
              cmd_o.lsel = LS_B1;
              state_d = S_M1D;
            end else begin
              state_d = S_REPL;
            end
          end else begin
            cmd_o.op = OP_SEL_T1;
            state_d = S_DEM;
          end
        end else if (sts_i.total_ge_c) begin
          if (sts_i.total_ge_2c && sts_i.b2_nz) begin
            cmd_o.op = OP_SCAN;
            cmd_o.smode = SM_LRU;
            cmd_o.lsel = LS_B2;
            state_d = S_M1D;
          end else begin
            state_d = S_REPL;
          end
        end else begin
          state_d = S_M3;
        end
      end
      S_M1D: begin
        if (sts_i.scan_done) begin
          cmd_o.op = OP_DROP;
          state_d = S_REPL;
        end
      end
      S_M3: begin
        ret_d = S_M4;
        state_d = sts_i.res_ge_c ? S_REPL : S_M4;
      end
      S_M4: begin
        cmd_o.op = OP_SCAN;
        cmd_o.smode = SM_NONE;
        state_d = S_M4W;
      end
      S_M4W: begin
        if (sts_i.scan_done) begin
          if (sts_i.scan_found) begin
            cmd_o.op = OP_TGT;
            mvl_d = LS_T1;
            state_d = S_MOVE;
          end else begin
            cmd_o.op = OP_SCAN;
            cmd_o.smode = SM_GHOST;
            state_d = S_M4G;
          end
        end
      end
      S_M4G: begin
        if (sts_i.scan_done) begin
          cmd_o.op = OP_TGT_DROP;
          mvl_d = LS_T1;
          state_d = S_MOVE;
        end
      end
      S_OUT: begin
        if (!sts_i.out_full) begin
          cmd_o.op = OP_OUT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      ret_q <= S_IDLE;
      mvl_q <= LS_T2;
      dem_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q <= ret_d;
      mvl_q <= mvl_d;
      dem_q <= dem_d;
    end
  end

endmodule

// ===== rtl/adaptive_replacement_policy_top.sv =====
// ARC replacement engine, one request at a time. Each request runs full directory
// scans (lookup, LRU searches, free slot search), and a ghost hit adds a
// repeated-subtraction divide. Scans walk the directory through the single read
// port of the directory memories. When the 32-bit recency stamp saturates, a
// renumbering pass of up to 129 scans runs once. A capacity write is taken only
// while idle and empties all lists. After reset and after each capacity write a
// clearing pass runs, during which neither the request nor the capacity channel
// is ready.
// Depends on arp_pkg, arp_ctrl and arp_dpath.
module adaptive_replacement_policy_top import arp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [KeyBits-1:0]  s_axis_tdata_i,   // key
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // key_echo, evict_valid, evict_key, evict_from_recent, target_p, zero pad
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic [ClsW-1:0]     m_axis_tuser_o,   // hit_class
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CapW-1:0]     cfg_data_i        // capacity
);

  cmd_t cmd;
  sts_t sts;

  arp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  arp_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .key_i       (s_axis_tdata_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o)
  );

`ifndef ASSERT_OFF
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request accepted while another is in progress");

  a_no_evict_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == CLS_T1 || m_axis_tuser_o == CLS_T2)
    |-> !m_axis_tdata_o[KeyBits])
    else $error("eviction reported on a resident hit");

  a_evict_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[KeyBits]
    |-> m_axis_tdata_o[2*KeyBits:KeyBits+1] == '0 && !m_axis_tdata_o[2*KeyBits+1])
    else $error("victim fields set without an eviction");
`endif

endmodule
